### sv/drc_pkg.sv
// ----------------------------------------------------------------------------
// drc_pkg
// Types and constants shared by the divider resistance averager modules.
// ----------------------------------------------------------------------------
package drc_pkg;

  localparam int SAMPLE_W = 12;
  localparam int REF_W    = 16;
  localparam int OHM_W    = 24;
  localparam int SUM_W    = 32;
  localparam int PROD_W   = REF_W + SAMPLE_W;
  localparam int DIV_W    = 32;
  localparam int STEP_W   = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [SAMPLE_W-1:0] NEAR_FULL_MARGIN = 12'd10;

  localparam logic [REF_W-1:0]    REFERENCE_RESET  = 16'd6500;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE_RESET = 12'd3055;
  localparam logic [OHM_W-1:0]    LIMIT_RESET      = 24'd1000000;

  localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 2'd2;

  typedef struct packed {
    logic                sat;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] span;
  } read_entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_RDIV_GO,
    B_RDIV_WAIT,
    B_ACC,
    B_AVG,
    B_EMIT
  } back_state_t;

endpackage

### sv/drc_front.sv
// ----------------------------------------------------------------------------
// drc_front
// Takes ADC requests and classifies each read as saturated or as a divide.
// ----------------------------------------------------------------------------
module drc_front import drc_pkg::*; (
  input  logic [SAMPLE_W-1:0] adc_sample,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] full_scale_count,
  output read_entry_t         entry,
  output logic                entry_valid,
  input  logic                entry_ready
);

  logic [SAMPLE_W-1:0] span;
  logic                below_full;

  always_comb begin
    below_full   = adc_sample < full_scale_count;
    span         = full_scale_count - adc_sample;
    entry.sample = adc_sample;
    entry.span   = span;
    entry.sat    = (adc_sample == '0) || !below_full || (span <= NEAR_FULL_MARGIN);
    entry_valid  = in_valid;
    in_ready     = entry_ready;
  end

endmodule

### sv/drc_queue.sv
// ----------------------------------------------------------------------------
// drc_queue
// Two-entry queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module drc_queue import drc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  read_entry_t push_entry,
  input  logic        push_valid,
  output logic        push_ready,
  output read_entry_t pop_entry,
  output logic        pop_valid,
  input  logic        pop_ready
);

  read_entry_t slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        do_push;
  logic        do_pop;

  always_comb begin
    push_ready = fill != 2'd2;
    pop_valid  = fill != 2'd0;
    pop_entry  = slots[rd_ptr];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

endmodule

### sv/drc_div.sv
// ----------------------------------------------------------------------------
// drc_div
// Restoring serial divider, one quotient bit per cycle; a new start restarts it.
// ----------------------------------------------------------------------------
module drc_div import drc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_W-1:0]    dividend,
  input  logic [SAMPLE_W-1:0] divisor,
  output logic                done,
  output logic [DIV_W-1:0]    quotient
);

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [SAMPLE_W-1:0] rem;
  logic [DIV_W-1:0]    acc;
  logic [SAMPLE_W-1:0] dsr;
  logic [SAMPLE_W:0]   trial;
  logic [SAMPLE_W:0]   diff;
  logic                q_bit;
  logic [SAMPLE_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, acc[DIV_W-1]};
    diff     = trial - {1'b0, dsr};
    q_bit    = trial >= {1'b0, dsr};
    rem_next = q_bit ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
    quotient = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      acc <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      acc <= {acc[DIV_W-2:0], q_bit};
    end
  end

endmodule

### sv/drc_back.sv
// ----------------------------------------------------------------------------
// drc_back
// Converts queued reads to ohms, accumulates a batch and emits its average.
// ----------------------------------------------------------------------------
module drc_back import drc_pkg::*; #(
  parameter int READS_PER_RESULT = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  read_entry_t      entry,
  input  logic             entry_valid,
  output logic             entry_ready,
  input  logic [REF_W-1:0] reference_ohms,
  input  logic [OHM_W-1:0] limit_ohms,
  output logic [OHM_W-1:0] resistance_ohms,
  output logic             out_valid,
  input  logic             out_ready
);

  localparam int CNT_W      = $clog2(READS_PER_RESULT + 1);
  // at most 16 reads per batch: any sum past AVG_W bits averages above the limit
  localparam int AVG_W      = OHM_W + 4;
  localparam int AVG_SHIFT  = $clog2(READS_PER_RESULT);
  localparam int RECIP_W    = AVG_W + 1;
  localparam int AVG_PROD_W = 2 * AVG_W + AVG_SHIFT + 1;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'd1 << (AVG_W + AVG_SHIFT)) + 64'(READS_PER_RESULT) - 64'd1) /
             64'(READS_PER_RESULT));

  back_state_t         state;
  back_state_t         state_next;
  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] span;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    val;
  logic [SUM_W-1:0]    ohm_sum;
  logic [CNT_W-1:0]    reads_taken;
  logic [CNT_W-1:0]    count_inc;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    sum_sat;
  logic                batch_done;
  logic                out_free;
  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [SAMPLE_W-1:0] div_divisor;
  logic                div_done;
  logic [DIV_W-1:0]    div_quotient;
  logic [AVG_W-1:0]    avg_in;
  logic [AVG_PROD_W-1:0] avg_prod;
  logic [AVG_W-1:0]    avg_quot;
  logic [AVG_W-1:0]    avg;
  logic [OHM_W-1:0]    avg_clamped;

  drc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    sum_wide    = {1'b0, ohm_sum} + {1'b0, val};
    sum_sat     = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    count_inc   = reads_taken + CNT_W'(1);
    batch_done  = count_inc == CNT_W'(READS_PER_RESULT);
    out_free    = !out_valid || out_ready;
    // average by reciprocal multiply, exact for every AVG_W-bit sum
    avg_in      = (ohm_sum[SUM_W-1:AVG_W] != '0) ? '1 : ohm_sum[AVG_W-1:0];
    avg_prod    = AVG_PROD_W'(avg_in) * AVG_PROD_W'(AVG_RECIP);
    avg_quot    = avg_prod[AVG_W+AVG_SHIFT +: AVG_W];
    avg_clamped = (avg > {{(AVG_W-OHM_W){1'b0}}, limit_ohms}) ? limit_ohms
                                                                : avg[OHM_W-1:0];

    state_next   = state;
    entry_ready  = 1'b0;
    div_start    = 1'b0;
    div_dividend = {{(DIV_W-PROD_W){1'b0}}, prod};
    div_divisor  = sample;
    case (state)
      B_IDLE: begin
        entry_ready = 1'b1;
        if (entry_valid) state_next = entry.sat ? B_ACC : B_MUL;
      end
      B_MUL:       state_next = B_RDIV_GO;
      B_RDIV_GO: begin
        div_start  = 1'b1;
        state_next = B_RDIV_WAIT;
      end
      B_RDIV_WAIT: if (div_done) state_next = B_ACC;
      B_ACC:       state_next = batch_done ? B_AVG : B_IDLE;
      B_AVG:       state_next = B_EMIT;
      B_EMIT:      if (out_free) state_next = B_IDLE;
      default:     state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      ohm_sum     <= '0;
      reads_taken <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_ACC: begin
          ohm_sum <= sum_sat;
          if (!batch_done) reads_taken <= count_inc;
        end
        B_EMIT: begin
          if (out_free) begin
            ohm_sum     <= '0;
            reads_taken <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        sample <= entry.sample;
        span   <= entry.span;
        val    <= {{(SUM_W-OHM_W){1'b0}}, limit_ohms};
      end
      B_MUL:       prod <= PROD_W'(reference_ohms) * PROD_W'(span);
      B_RDIV_WAIT: if (div_done) val <= div_quotient;
      B_AVG:       avg <= avg_quot;
      B_EMIT:      if (out_free) resistance_ohms <= avg_clamped;
      default: ;
    endcase
  end

endmodule

### sv/divider_resistance_averager.sv
// ----------------------------------------------------------------------------
// divider_resistance_averager
// Converts voltage divider ADC reads to ohms and emits a clamped batch average.
//
//   channel  signals                                  direction
//   in       in_valid, in_ready, adc_sample           request in
//   out      out_valid, out_ready, resistance_ohms    request out
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  register write in
//
// A read that needs a divide holds the back end through the multiply, the
// serial divide (one bit per cycle) and the accumulate; a saturated read goes
// straight to it. The last read of a batch also passes the averaging multiply
// and output register, held while an earlier result still waits on out_ready.
// A two-entry queue lets the front take reads while the back is busy.
// Reset is synchronous; it restores the register defaults and clears the batch.
// ----------------------------------------------------------------------------
module divider_resistance_averager import drc_pkg::*; #(
  parameter int READS_PER_RESULT = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SAMPLE_W-1:0]  adc_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OHM_W-1:0]     resistance_ohms,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OHM_W-1:0]     cfg_data
);

  logic [REF_W-1:0]    reference_ohms;
  logic [SAMPLE_W-1:0] full_scale_count;
  logic [OHM_W-1:0]    limit_ohms;
  read_entry_t         front_entry;
  logic                front_valid;
  logic                front_ready;
  read_entry_t         queue_entry;
  logic                queue_valid;
  logic                queue_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_ohms   <= REFERENCE_RESET;
      full_scale_count <= FULL_SCALE_RESET;
      limit_ohms       <= LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_REFERENCE:  reference_ohms   <= cfg_data[REF_W-1:0];
        CFG_FULL_SCALE: full_scale_count <= cfg_data[SAMPLE_W-1:0];
        CFG_LIMIT:      limit_ohms       <= cfg_data;
        default: ;
      endcase
    end
  end

  drc_front u_front (
    .adc_sample       (adc_sample),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .full_scale_count (full_scale_count),
    .entry            (front_entry),
    .entry_valid      (front_valid),
    .entry_ready      (front_ready)
  );

  drc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_entry (front_entry),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_entry  (queue_entry),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready)
  );

  drc_back #(
    .READS_PER_RESULT (READS_PER_RESULT)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .entry           (queue_entry),
    .entry_valid     (queue_valid),
    .entry_ready     (queue_ready),
    .reference_ohms  (reference_ohms),
    .limit_ohms      (limit_ohms),
    .resistance_ohms (resistance_ohms),
    .out_valid       (out_valid),
    .out_ready       (out_ready)
  );

endmodule

### tb/tb_divider_resistance_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_divider_resistance_averager
// Drives ADC reads into the divider resistance averager under random
// handshake gaps and compares every batch average with a local predictor.
// Register settings change between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_divider_resistance_averager;
  import drc_pkg::*;

  localparam int          READS          = 5;
  localparam int          SETTLE_CYCLES  = 200;
  localparam int unsigned CYCLE_LIMIT    = 600000;
  localparam int          RANDOM_PHASES  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  adc_sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OHM_W-1:0]     resistance_ohms;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [OHM_W-1:0]     cfg_data = '0;

  // register mirror and batch state of the predictor
  logic [REF_W-1:0]    series_ohms = REFERENCE_RESET;
  logic [SAMPLE_W-1:0] open_count  = FULL_SCALE_RESET;
  logic [OHM_W-1:0]    clamp_ohms  = LIMIT_RESET;
  logic [SUM_W-1:0]    batch_sum   = '0;
  int unsigned         batch_reads = 0;

  logic [SAMPLE_W-1:0] sample_q[$];
  logic [OHM_W-1:0]    average_q[$];

  int unsigned reads_queued = 0;
  int unsigned reads_accepted = 0;
  int unsigned averages_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;

  divider_resistance_averager #(
    .READS_PER_RESULT(READS)
  ) u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .adc_sample      (adc_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .resistance_ohms (resistance_ohms),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (idle_pct == 0) return 0;
    r = $urandom_range(99);
    if (r >= idle_pct) return 0;
    if (r < idle_pct / 10) return $urandom_range(60, 15);
    return $urandom_range(4, 1);
  endfunction

  function automatic logic [SUM_W-1:0] ohms_for_sample(logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] span;
    logic [63:0]         prod;
    if (s == '0 || s >= open_count) return SUM_W'(clamp_ohms);
    span = open_count - s;
    if (span <= NEAR_FULL_MARGIN) return SUM_W'(clamp_ohms);
    prod = 64'(series_ohms) * 64'(span);
    return SUM_W'(prod / 64'(s));
  endfunction

  function automatic void take_read(logic [SAMPLE_W-1:0] s);
    logic [SUM_W-1:0] val;
    logic [SUM_W:0]   total;
    logic [SUM_W-1:0] avg;
    val = ohms_for_sample(s);
    total = {1'b0, batch_sum} + {1'b0, val};
    batch_sum = total[SUM_W] ? '1 : total[SUM_W-1:0];
    batch_reads++;
    if (batch_reads == READS) begin
      avg = batch_sum / SUM_W'(READS);
      if (avg > SUM_W'(clamp_ohms)) avg = SUM_W'(clamp_ohms);
      average_q.push_back(avg[OHM_W-1:0]);
      batch_sum = '0;
      batch_reads = 0;
    end
  endfunction

  function automatic void report_mismatch(logic [OHM_W-1:0] want, logic [OHM_W-1:0] got,
                                          bit orphan);
    if (mismatches < 10) begin
      if (orphan)
        $display("resistance_ohms %0d with no request pending", got);
      else
        $display("resistance_ohms mismatch: expected %0d, got %0d", want, got);
    end
    mismatches++;
  endfunction

  // request driver
  always @(posedge clk) begin
    bit busy;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        take_read(adc_sample);
        reads_accepted++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          adc_sample <= sample_q.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    logic [OHM_W-1:0] want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        averages_seen++;
        if (average_q.size() == 0) begin
          report_mismatch('0, resistance_ohms, 1'b1);
        end else begin
          want = average_q.pop_front();
          if (resistance_ohms !== want) report_mismatch(want, resistance_ohms, 1'b0);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_ready <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [OHM_W-1:0] data);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_REFERENCE:  series_ohms = data[REF_W-1:0];
      CFG_FULL_SCALE: open_count  = data[SAMPLE_W-1:0];
      CFG_LIMIT:      clamp_ohms  = data;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [OHM_W-1:0] ref_val, logic [OHM_W-1:0] fs_val,
                          logic [OHM_W-1:0] lim_val);
    write_reg(CFG_REFERENCE, ref_val);
    write_reg(CFG_FULL_SCALE, fs_val);
    write_reg(CFG_LIMIT, lim_val);
  endtask

  task automatic queue_read(logic [SAMPLE_W-1:0] s);
    sample_q.push_back(s);
    reads_queued++;
  endtask

  // waits until all reads are accepted and all averages are back, then lets the back end settle
  task automatic drain();
    while (reads_accepted != reads_queued || average_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    int unsigned r;
    int          near;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return SAMPLE_W'($urandom_range(8, 1));
    if (r < 24) return '1;
    if (r < 40) begin
      near = int'(open_count) + $urandom_range(3) - $urandom_range(14);
      if (near < 0) near = 0;
      if (near > 4095) near = 4095;
      return SAMPLE_W'(near);
    end
    return SAMPLE_W'($urandom_range(4095));
  endfunction

  initial begin
    int unsigned         n;
    logic [SAMPLE_W-1:0] picks[$];
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero read, smallest read, both sides of the margin, top
    idle_pct = 0;
    picks = {12'd0, 12'd1, 12'd3044, 12'd3045, 12'd3055, 12'd4095, 12'd1527,
             12'd2048, 12'd100, 12'd4000};
    foreach (picks[i]) queue_read(picks[i]);
    drain();

    // widest registers: unclamped reads far above the limit, clamped average
    set_regs(24'd65535, 24'd4095, 24'hFFFFFF);
    idle_pct = 30;
    picks = {12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd4084, 12'd4085, 12'd4094,
             12'd2047, 12'd4095};
    foreach (picks[i]) queue_read(picks[i]);
    drain();

    // zero reference, plus a write to the unused index
    set_regs(24'd0, 24'd2000, 24'd500);
    write_reg(CFG_UNUSED, 24'($urandom_range(24'hFFFFFF)));
    idle_pct = 60;
    picks = {12'd1000, 12'd1, 12'd1990, 12'd0, 12'd4095};
    foreach (picks[i]) queue_read(picks[i]);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 6)
        0: set_regs(24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)),
                    24'($urandom_range(24'hFFFFFF)));
        1: set_regs(24'd65535, 24'd4095, 24'hFFFFFF);
        2: set_regs(24'd1, 24'd1, 24'd0);
        3: set_regs(24'd0, 24'd3055, 24'($urandom_range(2000000)));
        4: set_regs(24'($urandom_range(65535, 1)), 24'd0, 24'($urandom_range(24'hFFFFFF)));
        default: set_regs(24'(REFERENCE_RESET), 24'(FULL_SCALE_RESET), LIMIT_RESET);
      endcase
      if (p == RANDOM_PHASES - 1) write_reg(CFG_UNUSED, 24'($urandom_range(24'hFFFFFF)));
      idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 25 : 60;
      n = $urandom_range(60, 40);
      repeat (n) queue_read(random_sample());
      drain();
    end

    $display("%0d reads over %0d register writes; %0d batch averages compared",
             reads_accepted, reg_writes, averages_seen);
    $display("%0d mismatches, %0d averages still pending", mismatches, average_q.size());
    if (mismatches == 0 && average_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
